// ===== sv/csa_pkg.sv =====
package csa_pkg;

    // Operation codes carried by the mode field
    localparam logic [1:0] MODE_ACC  = 2'd0;
    localparam logic [1:0] MODE_READ = 2'd1;
    localparam logic [1:0] MODE_CLR  = 2'd2;

    // Per-entry accumulator record
    typedef struct packed {
        logic [47:0]        pnow;
        logic [62:0]        ptot;
        logic [47:0]        ppeak;
        logic signed [48:0] cre_now;
        logic signed [48:0] cim_now;
        logic signed [63:0] cre_tot;
        logic signed [63:0] cim_tot;
        logic signed [48:0] cre_pk;
        logic signed [48:0] cim_pk;
    } t_rec;

    // Saturating add of a 49-bit cross value into a 64-bit sum
    function automatic logic signed [63:0] sat_add64(
        input logic signed [63:0] a,
        input logic signed [48:0] b
    );
        logic [64:0] s;
        s = {a[63], a} + {{16{b[48]}}, b};
        if (s[64] != s[63]) begin
            sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            sat_add64 = s[63:0];
        end
    endfunction

endpackage

// ===== sv/cross_spectrum_accumulator_core.sv =====
// Per-bin power and cross-spectrum accumulator.
// Input channel: command style. An item (mode, channel, bin, re, im,
// last_bin) is taken at a rising edge where start is high and busy is low.
// Mode accumulate updates the entry of (channel, bin); channel 0 also
// stores its bin as the reference, channel 1 forms cross products with it.
// Mode read returns one result; mode clear zeroes the entry (bin 0 also
// zeroes the channel's block count). Out-of-range items are dropped.
// Result channel: o_strobe is high for one cycle with the fields of a read;
// the receiver cannot stall, so nothing is held back.
// Throughput: one item per cycle while busy is low. A read result is on the
// result ports after the memory read, multiply, sum and update/write-back
// stages and the result register. Back-to-back items to the same entry are
// resolved by forwarding the three most recent write-backs.
// Reset: a clearing pass sweeps all CHANNELS*(BLOCK_SIZE/2+1) entries, one
// per cycle (4098 entries at default sizes), with busy high; block counts
// clear at once. The reference store is not cleared.
module cross_spectrum_accumulator_core #(
    parameter int BLOCK_SIZE = 4096,
    parameter int CHANNELS   = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_mode,
    input  logic [2:0]         i_channel,
    input  logic [11:0]        i_bin,
    input  logic signed [23:0] i_bin_re,
    input  logic signed [23:0] i_bin_im,
    input  logic               i_last_bin,
    output logic               o_strobe,
    output logic [47:0]        o_power_now,
    output logic [62:0]        o_power_total,
    output logic [47:0]        o_power_peak,
    output logic signed [63:0] o_cross_re_total,
    output logic signed [63:0] o_cross_im_total,
    output logic signed [48:0] o_cross_re_now,
    output logic signed [48:0] o_cross_im_now,
    output logic signed [48:0] o_cross_re_at_peak,
    output logic signed [48:0] o_cross_im_at_peak,
    output logic [31:0]        o_blocks_seen
);
    import csa_pkg::*;

    localparam int NBINS = BLOCK_SIZE / 2 + 1;
    localparam int NENT  = CHANNELS * NBINS;
    localparam int EW    = $clog2(NENT);
    localparam int BW    = $clog2(NBINS);
    localparam int CW    = $clog2(CHANNELS);

    // Clearing pass
    logic          r_clr_busy;
    logic [EW-1:0] r_clr_addr;

    // Input decode
    logic          in_acc;
    logic          in_ok;
    logic [EW-1:0] in_addr;
    logic [BW-1:0] ref_idx;

    assign busy    = r_clr_busy;
    assign in_acc  = start && !r_clr_busy;
    assign in_ok   = in_acc && (32'(i_channel) < CHANNELS) && (32'(i_bin) < NBINS)
                     && (i_mode != 2'd3);
    assign in_addr = EW'(32'(i_channel) * NBINS + 32'(i_bin));
    assign ref_idx = BW'(i_bin);

    // Reference store, written by channel 0 at accept
    logic signed [23:0] ref_re_mem [NBINS];
    logic signed [23:0] ref_im_mem [NBINS];
    logic signed [23:0] r_ref_re_q;
    logic signed [23:0] r_ref_im_q;

    always_ff @(posedge i_clk) begin
        if (in_ok && i_mode == MODE_ACC && i_channel == 3'd0) begin
            ref_re_mem[ref_idx] <= i_bin_re;
            ref_im_mem[ref_idx] <= i_bin_im;
        end
        r_ref_re_q <= ref_re_mem[ref_idx];
        r_ref_im_q <= ref_im_mem[ref_idx];
    end

    // Stage 1: memory data arrives
    logic               r1_valid;
    logic [1:0]         r1_mode;
    logic [2:0]         r1_ch;
    logic [11:0]        r1_bin;
    logic signed [23:0] r1_re;
    logic signed [23:0] r1_im;
    logic               r1_last;
    logic [EW-1:0]      r1_addr;
    t_rec               mem_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= in_ok;
        end
        r1_mode <= i_mode;
        r1_ch   <= i_channel;
        r1_bin  <= i_bin;
        r1_re   <= i_bin_re;
        r1_im   <= i_bin_im;
        r1_last <= i_last_bin;
        r1_addr <= in_addr;
    end

    // Stage 2: products
    logic               r2_valid;
    logic [1:0]         r2_mode;
    logic [2:0]         r2_ch;
    logic [11:0]        r2_bin;
    logic               r2_last;
    logic [EW-1:0]      r2_addr;
    t_rec               r2_rec;
    logic signed [47:0] r2_prr, r2_pii, r2_xa, r2_xb, r2_xc, r2_xd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_mode <= r1_mode;
        r2_ch   <= r1_ch;
        r2_bin  <= r1_bin;
        r2_last <= r1_last;
        r2_addr <= r1_addr;
        r2_rec  <= mem_q;
        r2_prr  <= 48'(r1_re) * 48'(r1_re);
        r2_pii  <= 48'(r1_im) * 48'(r1_im);
        r2_xa   <= 48'(r_ref_re_q) * 48'(r1_re);
        r2_xb   <= 48'(r_ref_im_q) * 48'(r1_im);
        r2_xc   <= 48'(r_ref_re_q) * 48'(r1_im);
        r2_xd   <= 48'(r_ref_im_q) * 48'(r1_re);
    end

    // Stage 3: sums
    logic               r3_valid;
    logic [1:0]         r3_mode;
    logic [2:0]         r3_ch;
    logic [11:0]        r3_bin;
    logic               r3_last;
    logic [EW-1:0]      r3_addr;
    t_rec               r3_rec;
    logic [47:0]        r3_p;
    logic signed [48:0] r3_cr, r3_ci;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
        r3_mode <= r2_mode;
        r3_ch   <= r2_ch;
        r3_bin  <= r2_bin;
        r3_last <= r2_last;
        r3_addr <= r2_addr;
        r3_rec  <= r2_rec;
        r3_p    <= r2_prr[47:0] + r2_pii[47:0];
        r3_cr   <= {r2_xa[47], r2_xa} + {r2_xb[47], r2_xb};
        r3_ci   <= {r2_xc[47], r2_xc} - {r2_xd[47], r2_xd};
    end

    // Write-back history for forwarding
    logic          r_h1_vld, r_h2_vld, r_h3_vld;
    logic [EW-1:0] r_h1_addr, r_h2_addr, r_h3_addr;
    t_rec          r_h1_rec, r_h2_rec, r_h3_rec;

    // Stage 4: forward, update, write back
    t_rec        old_rec;
    t_rec        new_rec;
    logic        newpeak;
    logic [63:0] ptot_sum;
    logic        wr_en;

    always_comb begin
        if (r_h1_vld && r_h1_addr == r3_addr) begin
            old_rec = r_h1_rec;
        end else if (r_h2_vld && r_h2_addr == r3_addr) begin
            old_rec = r_h2_rec;
        end else if (r_h3_vld && r_h3_addr == r3_addr) begin
            old_rec = r_h3_rec;
        end else begin
            old_rec = r3_rec;
        end
    end

    always_comb begin
        newpeak  = r3_p > old_rec.ppeak;
        ptot_sum = {1'b0, old_rec.ptot} + {16'd0, r3_p};
        new_rec  = old_rec;
        wr_en    = 1'b0;
        case (r3_mode)
            MODE_ACC: begin
                wr_en        = r3_valid;
                new_rec.pnow = r3_p;
                new_rec.ptot = ptot_sum[63] ? {63{1'b1}} : ptot_sum[62:0];
                if (newpeak) begin
                    new_rec.ppeak = r3_p;
                end
                if (r3_ch == 3'd1) begin
                    new_rec.cre_now = r3_cr;
                    new_rec.cim_now = r3_ci;
                    new_rec.cre_tot = sat_add64(old_rec.cre_tot, r3_cr);
                    new_rec.cim_tot = sat_add64(old_rec.cim_tot, r3_ci);
                    if (newpeak) begin
                        new_rec.cre_pk = r3_cr;
                        new_rec.cim_pk = r3_ci;
                    end
                end
            end
            MODE_CLR: begin
                wr_en   = r3_valid;
                new_rec = '0;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h1_vld <= 1'b0;
            r_h2_vld <= 1'b0;
            r_h3_vld <= 1'b0;
        end else begin
            r_h1_vld <= wr_en;
            r_h2_vld <= r_h1_vld;
            r_h3_vld <= r_h2_vld;
        end
        r_h1_addr <= r3_addr;
        r_h2_addr <= r_h1_addr;
        r_h3_addr <= r_h2_addr;
        r_h1_rec  <= new_rec;
        r_h2_rec  <= r_h1_rec;
        r_h3_rec  <= r_h2_rec;
    end

    // Entry memory: clearing pass owns the write port after reset
    logic          ram_we;
    logic [EW-1:0] ram_waddr;
    t_rec          ram_wdata;

    assign ram_we    = r_clr_busy || wr_en;
    assign ram_waddr = r_clr_busy ? r_clr_addr : r3_addr;
    assign ram_wdata = r_clr_busy ? '0 : new_rec;

    csa_ram #(
        .DEPTH (NENT),
        .AW    (EW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (in_addr),
        .o_rdata (mem_q)
    );

    // Sweep all entries after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == EW'(NENT - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + EW'(1);
        end
    end

    // Block counts per channel
    logic [31:0] r_blk [CHANNELS];
    logic [CW-1:0] blk_idx;

    assign blk_idx = CW'(r3_ch);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_blk[i] <= '0;
            end
        end else if (r3_valid) begin
            if (r3_mode == MODE_ACC && r3_last && r_blk[blk_idx] != 32'hFFFF_FFFF) begin
                r_blk[blk_idx] <= r_blk[blk_idx] + 32'd1;
            end else if (r3_mode == MODE_CLR && r3_bin == 12'd0) begin
                r_blk[blk_idx] <= '0;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r3_valid && r3_mode == MODE_READ;
        end
        o_power_now        <= old_rec.pnow;
        o_power_total      <= old_rec.ptot;
        o_power_peak       <= old_rec.ppeak;
        o_cross_re_total   <= old_rec.cre_tot;
        o_cross_im_total   <= old_rec.cim_tot;
        o_cross_re_now     <= old_rec.cre_now;
        o_cross_im_now     <= old_rec.cim_now;
        o_cross_re_at_peak <= old_rec.cre_pk;
        o_cross_im_at_peak <= old_rec.cim_pk;
        o_blocks_seen      <= r_blk[blk_idx];
    end

    // No item enters the pipeline during the clearing pass
    a_no_item_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |=> !r1_valid)
        else $error("item entered during clearing pass");

    // A result only follows a read in the last stage
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r3_valid && r3_mode == MODE_READ))
        else $error("result without read");

    // Pipeline writes never collide with the clearing sweep
    a_no_wr_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !wr_en)
        else $error("write-back during clearing pass");

    // Reads never write the entry memory
    a_read_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_valid && r3_mode == MODE_READ) |-> !wr_en)
        else $error("read wrote an entry");

endmodule

// ===== sv/csa_ram.sv =====
module csa_ram #(
    parameter int DEPTH = 4098,
    parameter int AW    = 13
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  csa_pkg::t_rec     i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output csa_pkg::t_rec     o_rdata
);
    import csa_pkg::*;

    t_rec r_mem [DEPTH];
    t_rec r_q;

    // Write one entry, read one entry, registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

// ===== dv/cross_spectrum_accumulator_core_test.sv =====
`timescale 1ns / 1ps

module cross_spectrum_accumulator_core_test;
    import csa_pkg::*;

    localparam int NBINS = 2049;
    localparam int NCH   = 2;
    localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint S64_MIN = 64'sh8000_0000_0000_0000;

    typedef struct {
        logic [1:0]         mode;
        logic [2:0]         channel;
        logic [11:0]        bin;
        logic signed [23:0] re;
        logic signed [23:0] im;
        logic               last;
        bit                 drain;
    } t_bin_item;

    typedef struct {
        logic [47:0]        pnow;
        logic [62:0]        ptot;
        logic [47:0]        ppeak;
        logic signed [63:0] cre_tot;
        logic signed [63:0] cim_tot;
        logic signed [48:0] cre_now;
        logic signed [48:0] cim_now;
        logic signed [48:0] cre_pk;
        logic signed [48:0] cim_pk;
        logic [31:0]        blocks;
    } t_readout;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_mode = MODE_ACC;
    logic [2:0]         i_channel = '0;
    logic [11:0]        i_bin = '0;
    logic signed [23:0] i_bin_re = '0;
    logic signed [23:0] i_bin_im = '0;
    logic               i_last_bin = 1'b0;
    logic               o_strobe;
    logic [47:0]        o_power_now;
    logic [62:0]        o_power_total;
    logic [47:0]        o_power_peak;
    logic signed [63:0] o_cross_re_total;
    logic signed [63:0] o_cross_im_total;
    logic signed [48:0] o_cross_re_now;
    logic signed [48:0] o_cross_im_now;
    logic signed [48:0] o_cross_re_at_peak;
    logic signed [48:0] o_cross_im_at_peak;
    logic [31:0]        o_blocks_seen;

    cross_spectrum_accumulator_core dut (.*);

    always #5 i_clk = ~i_clk;

    // Shadow copy of the accumulator memory
    longint  ref_re [NBINS];
    longint  ref_im [NBINS];
    bit      ref_written [NBINS];
    longint  pw_now [NCH][NBINS];
    longint  pw_tot [NCH][NBINS];
    longint  pw_peak [NCH][NBINS];
    longint  cx_now [NCH][NBINS][2];
    longint  cx_tot [NCH][NBINS][2];
    longint  cx_pk [NCH][NBINS][2];
    longint  blk_count [NCH];

    t_bin_item pending_items[$];
    t_readout  expected_reads[$];
    t_bin_item cur;
    bit        taken = 0;
    int        accepted = 0;
    int        quiet = 0;
    int        total_items = 0;
    bit        failed = 0;

    function automatic longint sat_sum(longint a, longint b);
        if (b > 0 && a > S64_MAX - b) return S64_MAX;
        if (b < 0 && a < S64_MIN - b) return S64_MIN;
        return a + b;
    endfunction

    // Apply one accepted item to the shadow memory, queue a readout if any
    task automatic apply_item(t_bin_item it);
        int c, b;
        longint re, im, p, cr, ci;
        bit newpeak;
        t_readout r;
        c = it.channel;
        b = it.bin;
        if (it.channel >= NCH || it.bin >= NBINS || it.mode == 2'd3) return;
        re = it.re;
        im = it.im;
        case (it.mode)
            MODE_ACC: begin
                p = re * re + im * im;
                newpeak = p > pw_peak[c][b];
                if (c == 0) begin
                    ref_re[b] = re;
                    ref_im[b] = im;
                end
                pw_now[c][b] = p;
                pw_tot[c][b] = (pw_tot[c][b] > S64_MAX - p) ? S64_MAX : pw_tot[c][b] + p;
                if (newpeak) pw_peak[c][b] = p;
                if (c == 1) begin
                    cr = ref_re[b] * re + ref_im[b] * im;
                    ci = ref_re[b] * im - ref_im[b] * re;
                    cx_now[c][b][0] = cr;
                    cx_now[c][b][1] = ci;
                    cx_tot[c][b][0] = sat_sum(cx_tot[c][b][0], cr);
                    cx_tot[c][b][1] = sat_sum(cx_tot[c][b][1], ci);
                    if (newpeak) begin
                        cx_pk[c][b][0] = cr;
                        cx_pk[c][b][1] = ci;
                    end
                end
                if (it.last && blk_count[c] != 64'hFFFF_FFFF) blk_count[c]++;
            end
            MODE_CLR: begin
                pw_now[c][b] = 0;
                pw_tot[c][b] = 0;
                pw_peak[c][b] = 0;
                cx_now[c][b] = '{0, 0};
                cx_tot[c][b] = '{0, 0};
                cx_pk[c][b] = '{0, 0};
                if (b == 0) blk_count[c] = 0;
            end
            MODE_READ: begin
                r.pnow    = pw_now[c][b];
                r.ptot    = pw_tot[c][b];
                r.ppeak   = pw_peak[c][b];
                r.cre_tot = cx_tot[c][b][0];
                r.cim_tot = cx_tot[c][b][1];
                r.cre_now = cx_now[c][b][0];
                r.cim_now = cx_now[c][b][1];
                r.cre_pk  = cx_pk[c][b][0];
                r.cim_pk  = cx_pk[c][b][1];
                r.blocks  = blk_count[c];
                expected_reads.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic check_field(string nm, logic [63:0] e, logic [63:0] a);
        if (e !== a) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, nm, e, a);
            failed = 1;
        end
    endtask

    // Queue one item, keeping track of which reference bins exist
    task automatic add(logic [1:0] m, logic [2:0] c, logic [11:0] b,
                       logic signed [23:0] re, logic signed [23:0] im, logic l);
        t_bin_item it;
        if (m == MODE_ACC && c == 1 && b < NBINS && !ref_written[b]) c = 0;
        if (m == MODE_ACC && c == 0 && b < NBINS) ref_written[b] = 1;
        it = '{m, c, b, re, im, l, 0};
        pending_items.push_back(it);
    endtask

    task automatic add_drain();
        t_bin_item it;
        it = '{MODE_READ, 0, 0, 0, 0, 0, 1};
        pending_items.push_back(it);
    endtask

    function automatic logic signed [23:0] pick_val();
        case ($urandom_range(0, 5))
            0: return 24'sh800000;
            1: return 24'sh7FFFFF;
            2: return 24'(int'($urandom_range(0, 15)) - 8);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [11:0] pick_bin();
        case ($urandom_range(0, 9))
            0: return 12'd2048;
            1: return 12'($urandom_range(0, 2048));
            default: return 12'($urandom_range(0, 5));
        endcase
    endfunction

    // Accept and predict at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            apply_item(cur);
            taken = 1;
            accepted++;
            quiet = 0;
        end else begin
            quiet++;
        end
    end

    // Present the next item at the falling edge
    always @(negedge i_clk) begin
        int idle_pct;
        if (!start || taken) begin
            taken = 0;
            idle_pct = (accepted < total_items / 3) ? 9 :
                       (accepted < 2 * total_items / 3) ? 58 : 0;
            if (pending_items.size() != 0 && pending_items[0].drain) begin
                // hold off until every readout has come back
                if (expected_reads.size() == 0 && quiet > 8) void'(pending_items.pop_front());
            end
            if (pending_items.size() != 0 && !pending_items[0].drain &&
                $urandom_range(0, 99) >= idle_pct) begin
                cur = pending_items.pop_front();
                i_mode     <= cur.mode;
                i_channel  <= cur.channel;
                i_bin      <= cur.bin;
                i_bin_re   <= cur.re;
                i_bin_im   <= cur.im;
                i_last_bin <= cur.last;
                start      <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Compare each readout with the oldest prediction
    always @(posedge i_clk) begin
        t_readout e;
        if (i_rst_n && o_strobe) begin
            if (expected_reads.size() == 0) begin
                $display("%0t: unexpected readout, power_now actual %h", $time, o_power_now);
                failed = 1;
            end else begin
                e = expected_reads.pop_front();
                check_field("power_now", e.pnow, o_power_now);
                check_field("power_total", e.ptot, o_power_total);
                check_field("power_peak", e.ppeak, o_power_peak);
                check_field("cross_re_total", e.cre_tot, o_cross_re_total);
                check_field("cross_im_total", e.cim_tot, o_cross_im_total);
                check_field("cross_re_now", e.cre_now, o_cross_re_now);
                check_field("cross_im_now", e.cim_now, o_cross_im_now);
                check_field("cross_re_at_peak", e.cre_pk, o_cross_re_at_peak);
                check_field("cross_im_at_peak", e.cim_pk, o_cross_im_at_peak);
                check_field("blocks_seen", e.blocks, o_blocks_seen);
            end
        end
    end

    initial begin
        #50ms;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic [11:0] b;
        int k;
        for (int i = 0; i < NBINS; i++) begin
            ref_re[i] = 0; ref_im[i] = 0; ref_written[i] = 0;
            for (int c = 0; c < NCH; c++) begin
                pw_now[c][i] = 0; pw_tot[c][i] = 0; pw_peak[c][i] = 0;
                cx_now[c][i] = '{0, 0}; cx_tot[c][i] = '{0, 0}; cx_pk[c][i] = '{0, 0};
            end
        end
        blk_count = '{0, 0};

        // Directed: extremes, peak rule, clears, ignored items
        add(MODE_ACC, 0, 0, 24'sh800000, 24'sh800000, 0);
        add(MODE_ACC, 1, 0, 24'sh7FFFFF, 24'sh800000, 1);
        add(MODE_READ, 0, 0, 0, 0, 0);
        add(MODE_READ, 1, 0, 0, 0, 0);
        add(MODE_ACC, 0, 2048, 24'sh7FFFFF, 24'sh7FFFFF, 1);
        add(MODE_ACC, 1, 2048, 0, 0, 0);
        add(MODE_ACC, 1, 2048, 24'sh800000, 24'sh7FFFFF, 0);
        add(MODE_ACC, 1, 2048, 3, -5, 0);
        add(MODE_READ, 1, 2048, 0, 0, 0);
        add(MODE_READ, 0, 2048, 0, 0, 0);
        add(MODE_CLR, 1, 0, 0, 0, 0);
        add(MODE_READ, 1, 0, 0, 0, 0);
        add(MODE_CLR, 0, 2048, 0, 0, 0);
        add(MODE_READ, 0, 2048, 0, 0, 0);
        add(MODE_READ, 0, 0, 0, 0, 0);
        add(2'd3, 0, 0, 0, 0, 0);
        add(MODE_READ, 7, 0, 24'sh7FFFFF, 0, 1);
        add(MODE_READ, 0, 12'hFFF, 0, 24'sh7FFFFF, 1);
        add(MODE_ACC, 2, 1, 5, 5, 1);
        add(MODE_ACC, 0, 12'd2049, 5, 5, 1);
        add(MODE_READ, 0, 1, 0, 0, 0);
        add_drain();

        // Random: mostly reference/measured/readout sequences, some noise
        for (int n = 0; n < 285; n++) begin
            b = pick_bin();
            k = $urandom_range(0, 99);
            if (k < 60) begin
                add(MODE_ACC, 0, b, pick_val(), pick_val(), $urandom_range(0, 3) == 0);
                add(MODE_ACC, 1, b, pick_val(), pick_val(), $urandom_range(0, 3) == 0);
                add(MODE_READ, 3'($urandom_range(0, 1)), b, 24'($urandom), 24'($urandom),
                    1'($urandom));
            end else if (k < 75) begin
                add(MODE_CLR, 3'($urandom_range(0, 1)), $urandom_range(0, 1) ? 12'd0 : b,
                    24'($urandom), 24'($urandom), 1'($urandom));
            end else if (k < 90) begin
                add(MODE_READ, 3'($urandom_range(0, 1)), b, 24'($urandom), 24'($urandom),
                    1'($urandom));
            end else begin
                add(2'($urandom), 3'($urandom), 12'($urandom), 24'($urandom), 24'($urandom),
                    1'($urandom));
            end
            if (n == 140) add_drain();
        end
        total_items = pending_items.size();

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_items.size() == 0 && !start);
        wait (expected_reads.size() == 0);
        repeat (20) @(posedge i_clk);
        if (!failed && expected_reads.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/csa_pkg.sv
sv/csa_ram.sv
sv/cross_spectrum_accumulator_core.sv
dv/cross_spectrum_accumulator_core_test.sv
